@@ rtl/pfc_pkg.sv @@
package pfc_pkg;

  localparam int unsigned PIX_W = 32;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned FMT_W = 3;

  typedef enum logic [FMT_W-1:0] {
    FMT_R8     = 3'd0,
    FMT_RG8    = 3'd1,
    FMT_RGB8   = 3'd2,
    FMT_RGBA8  = 3'd3,
    FMT_RGB565 = 3'd4,
    FMT_RGBA4  = 3'd5,
    FMT_RGB5A1 = 3'd6,
    FMT_BGRA8  = 3'd7
  } fmt_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SRC_FMT = 1'b0,
    CFG_DST_FMT = 1'b1
  } cfg_idx_t;

  // what stage 2 builds from the unpacked channels
  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_R8,
    KIND_RG8,
    KIND_RGB8,
    KIND_RGBA8,
    KIND_565,
    KIND_4444,
    KIND_5551
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    fmt_t             fmt;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [7:0]       a;
    logic [PIX_W-1:0] px;
    logic             last;
  } s1_t;

  typedef struct packed {
    fmt_t             fmt;
    logic [CNT_W-1:0] cnt;
    logic [PIX_W-1:0] res;
    logic             last;
  } s2_t;

  // bytes per pixel of a format
  function automatic logic [CNT_W-1:0] fmt_bytes(fmt_t f);
    logic [CNT_W-1:0] n;
    unique case (f)
      FMT_R8:     n = 3'd1;
      FMT_RG8:    n = 3'd2;
      FMT_RGB8:   n = 3'd3;
      FMT_RGBA8:  n = 3'd4;
      FMT_RGB565: n = 3'd2;
      FMT_RGBA4:  n = 3'd2;
      FMT_RGB5A1: n = 3'd2;
      FMT_BGRA8:  n = 3'd4;
      default:    n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/pfc_if.sv @@
interface pfc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  logic        last_in;

  modport source (output valid, output pixel_in, output last_in, input ready);
  modport sink   (input valid, input pixel_in, input last_in, output ready);
endinterface

interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic [2:0]  byte_count;
  logic [2:0]  format_used;
  logic        last_out;

  modport source (output valid, output pixel_out, output byte_count, output format_used,
                  output last_out, input ready);
  modport sink   (input valid, input pixel_out, input byte_count, input format_used,
                  input last_out, output ready);
endinterface

interface pfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [2:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pixel_format_converter.sv @@
// Pixel format converter: one pixel in, one converted pixel out.
// Channels:
//   in_ch  - pixel_in (byte 0 in bits 7:0, 16-bit formats in 15:0) and last_in.
//   out_ch - pixel_out (unused upper bytes zero), byte_count (1..4),
//            format_used (target, or source when the pair passes through), last_out.
//   cfg_ch - index 0 writes source_format, index 1 target_format; always ready.
//            Write only while no item is in flight.
// Formats: 0 R8, 1 RG8, 2 RGB8, 3 RGBA8, 4 RGB565, 5 RGBA4, 6 RGB5A1, 7 BGRA8.
// Pipeline: three register stages (unpack, pack, byte mask / output register).
//   An accepted item moves through the unpack, pack and output registers in turn to out_ch.
//   Throughput: one item per cycle while out_ch is not stalled, no bubbles.
// Reset (rst_n low, synchronous): pipeline emptied, both formats back to RGBA8
//   (so the block passes pixels through).
// Backpressure: each stage holds its item while the next one is full and stalled;
//   in_ch.ready drops only once all three stages hold items and out_ch is stalled.
//   Nothing is dropped or repeated.
module pixel_format_converter (
  input  logic       clk,
  input  logic       rst_n,
  pfc_in_if.sink     in_ch,
  pfc_out_if.source  out_ch,
  pfc_cfg_if.sink    cfg_ch
);
  import pfc_pkg::*;

  // configuration
  fmt_t src_fmt_r;
  fmt_t dst_fmt_r;

  // stage handshakes
  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  s1_t  s1;
  s2_t  s2;

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic [CNT_W-1:0] cnt_r;
  fmt_t             fmt_r;
  logic             last_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= FMT_RGBA8;
      dst_fmt_r <= FMT_RGBA8;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_SRC_FMT: src_fmt_r <= fmt_t'(cfg_ch.data);
        CFG_DST_FMT: dst_fmt_r <= fmt_t'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  pfc_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .src_fmt  (src_fmt_r),
    .dst_fmt  (dst_fmt_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .pixel_in (in_ch.pixel_in),
    .last_in  (in_ch.last_in),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  pfc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  // Stage 3: clear bytes above byte_count. Only the passthrough path can carry
  // stray upper bytes, but masking every item keeps the rule in one place.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pix_nxt[8*i +: 8] = (s2.cnt > CNT_W'(i)) ? s2.res[8*i +: 8] : 8'h00;
    end
  end

  assign s2_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      pix_r  <= pix_nxt;
      cnt_r  <= s2.cnt;
      fmt_r  <= s2.fmt;
      last_r <= s2.last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_out   = pix_r;
  assign out_ch.byte_count  = cnt_r;
  assign out_ch.format_used = fmt_r;
  assign out_ch.last_out    = last_r;

endmodule

@@ rtl/pfc_unpack.sv @@
// Stage 1: classify the format pair and unpack the pixel into 8-bit channels.
module pfc_unpack (
  input  logic           clk,
  input  logic           rst_n,
  input  pfc_pkg::fmt_t  src_fmt,
  input  pfc_pkg::fmt_t  dst_fmt,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    pixel_in,
  input  logic           last_in,
  output logic           s1_valid,
  input  logic           s1_ready,
  output pfc_pkg::s1_t   s1
);
  import pfc_pkg::*;

  logic       valid_r;
  s1_t        data_r;
  s1_t        data_nxt;
  logic [7:0] b0, b1, b2, b3;
  logic [15:0] w;

  assign b0 = pixel_in[7:0];
  assign b1 = pixel_in[15:8];
  assign b2 = pixel_in[23:16];
  assign b3 = pixel_in[31:24];
  assign w  = pixel_in[15:0];

  always_comb begin
    data_nxt      = '0;
    data_nxt.px   = pixel_in;
    data_nxt.last = last_in;

    // channels are the effective values the target byte slots take
    unique case (src_fmt)
      FMT_R8: begin
        data_nxt.r = b0;
        data_nxt.g = (dst_fmt == FMT_RG8) ? 8'hFF : b0;
        data_nxt.b = b0;
        data_nxt.a = (dst_fmt == FMT_RGBA8) ? b0 : 8'hFF;
      end
      FMT_RG8: begin
        data_nxt.r = (dst_fmt == FMT_R8) ? b1 : b0;
        data_nxt.g = b1;
        data_nxt.b = b0;
        data_nxt.a = b1;
      end
      FMT_RGB8: begin
        data_nxt.r = b0;
        data_nxt.g = b1;
        data_nxt.b = b2;
        data_nxt.a = 8'hFF;
      end
      FMT_RGBA8: begin
        data_nxt.r = b0;
        data_nxt.g = b1;
        data_nxt.b = b2;
        data_nxt.a = b3;
      end
      FMT_RGB565: begin
        data_nxt.r = {w[15:11], 3'b000};
        data_nxt.g = {w[10:5], 2'b00};
        data_nxt.b = {w[4:0], 3'b000};
        data_nxt.a = 8'hFF;
      end
      FMT_RGBA4: begin
        // nibble times 17 is the nibble repeated
        data_nxt.r = {w[15:12], w[15:12]};
        data_nxt.g = {w[11:8], w[11:8]};
        data_nxt.b = {w[7:4], w[7:4]};
        data_nxt.a = {w[3:0], w[3:0]};
      end
      FMT_RGB5A1: begin
        data_nxt.r = {w[15:11], 3'b000};
        data_nxt.g = {w[10:6], 3'b000};
        data_nxt.b = {w[5:1], 3'b000};
        data_nxt.a = {8{w[0]}};
      end
      FMT_BGRA8: begin
        data_nxt.r = b2;
        data_nxt.g = b1;
        data_nxt.b = b0;
        data_nxt.a = b3;
      end
      default: begin
        data_nxt.r = b0;
        data_nxt.g = b1;
        data_nxt.b = b2;
        data_nxt.a = b3;
      end
    endcase

    if (src_fmt == dst_fmt) begin
      data_nxt.kind = KIND_PASS;
    end else if (src_fmt <= FMT_RGBA8) begin
      unique case (dst_fmt)
        FMT_R8:     data_nxt.kind = KIND_R8;
        FMT_RG8:    data_nxt.kind = KIND_RG8;
        FMT_RGB8:   data_nxt.kind = KIND_RGB8;
        FMT_RGBA8:  data_nxt.kind = KIND_RGBA8;
        FMT_RGB565: data_nxt.kind = KIND_565;
        FMT_RGBA4:  data_nxt.kind = KIND_4444;
        FMT_RGB5A1: data_nxt.kind = KIND_5551;
        FMT_BGRA8:  data_nxt.kind = KIND_PASS;
        default:    data_nxt.kind = KIND_PASS;
      endcase
    end else begin
      data_nxt.kind = (dst_fmt == FMT_RGBA8) ? KIND_RGBA8 : KIND_PASS;
    end

    data_nxt.fmt = (data_nxt.kind == KIND_PASS) ? src_fmt : dst_fmt;
  end

  assign in_ready = !valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1       = data_r;

endmodule

@@ rtl/pfc_pack.sv @@
// Stage 2: pack channels into the target layout (or pass the raw pixel through), pick the byte count.
module pfc_pack (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  output logic          s1_ready,
  input  pfc_pkg::s1_t  s1,
  output logic          s2_valid,
  input  logic          s2_ready,
  output pfc_pkg::s2_t  s2
);
  import pfc_pkg::*;

  logic valid_r;
  s2_t  data_r;
  s2_t  data_nxt;

  always_comb begin
    data_nxt      = '0;
    data_nxt.fmt  = s1.fmt;
    data_nxt.last = s1.last;
    unique case (s1.kind)
      KIND_R8: begin
        data_nxt.res = {24'h0, s1.r};
        data_nxt.cnt = 3'd1;
      end
      KIND_RG8: begin
        data_nxt.res = {16'h0, s1.g, s1.r};
        data_nxt.cnt = 3'd2;
      end
      KIND_RGB8: begin
        data_nxt.res = {8'h0, s1.b, s1.g, s1.r};
        data_nxt.cnt = 3'd3;
      end
      KIND_RGBA8: begin
        data_nxt.res = {s1.a, s1.b, s1.g, s1.r};
        data_nxt.cnt = 3'd4;
      end
      KIND_565: begin
        data_nxt.res = {16'h0, s1.r[7:3], s1.g[7:2], s1.b[7:3]};
        data_nxt.cnt = 3'd2;
      end
      KIND_4444: begin
        data_nxt.res = {16'h0, s1.r[7:4], s1.g[7:4], s1.b[7:4], s1.a[7:4]};
        data_nxt.cnt = 3'd2;
      end
      KIND_5551: begin
        data_nxt.res = {16'h0, s1.r[7:3], s1.g[7:3], s1.b[7:3], s1.a[7]};
        data_nxt.cnt = 3'd2;
      end
      KIND_PASS: begin
        data_nxt.res = s1.px;
        data_nxt.cnt = fmt_bytes(s1.fmt);
      end
      default: begin
        data_nxt.res = s1.px;
        data_nxt.cnt = fmt_bytes(s1.fmt);
      end
    endcase
  end

  assign s1_ready = !valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_ready) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      data_r <= data_nxt;
    end
  end

  assign s2_valid = valid_r;
  assign s2       = data_r;

endmodule

@@ rtl/pfc_checker.sv @@
module pfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] byte_count,
  input logic [2:0] format_used
);
  import pfc_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid right after reset");

  // a stalled result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  // input backs up only when every stage is full and the output is stalled
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // byte count is 1..4 and fits the reported format
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> byte_count >= 3'd1 && byte_count <= 3'd4)
    else $error("byte count out of range");

  a_cnt_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_count == 3'd3 |-> format_used == FMT_RGB8)
    else $error("three bytes reported for a format other than RGB8");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .byte_count  (out_ch.byte_count),
  .format_used (out_ch.format_used)
);
